>>> rtl/clp_pkg.sv
// ----------------------------------------------------------------------------
// clp_pkg
// Shared types, constants and line-shape tables for the chapter list parser.
// ----------------------------------------------------------------------------
package clp_pkg;

    localparam int NAME_COUNT_BITS_DEF = 16;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] DIGIT_MARK   = 8'd0;

    localparam int TIME_LINE_LEN  = 22;
    localparam int TIME_LINE_LAST = 21;
    localparam int NAME_START     = 14;
    localparam int HOUR_MAX       = 23;
    localparam int MINUTE_MAX     = 59;
    localparam int SECOND_MAX     = 59;

    typedef enum logic [2:0] {
        KIND_NAME_BYTE = 3'd0,
        KIND_TIME      = 3'd1,
        KIND_CHAPTER   = 3'd2,
        KIND_ERROR     = 3'd3,
        KIND_END       = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_TIME  = 3'd1,
        ERR_HOUR      = 3'd2,
        ERR_MINUTE    = 3'd3,
        ERR_SECOND    = 3'd4,
        ERR_BAD_NAME  = 3'd5
    } err_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // "CHAPTERdd=dd:dd:dd.ddd", digit positions give DIGIT_MARK
    function automatic logic [7:0] time_shape(input logic [4:0] idx);
        logic [7:0] ch;
        unique case (idx)
            5'd0:  ch = "C";
            5'd1:  ch = "H";
            5'd2:  ch = "A";
            5'd3:  ch = "P";
            5'd4:  ch = "T";
            5'd5:  ch = "E";
            5'd6:  ch = "R";
            5'd9:  ch = "=";
            5'd12: ch = ":";
            5'd15: ch = ":";
            5'd18: ch = ".";
            default: ch = DIGIT_MARK;
        endcase
        return ch;
    endfunction

    // "CHAPTERddNAME="
    function automatic logic [7:0] name_shape(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:  ch = "C";
            4'd1:  ch = "H";
            4'd2:  ch = "A";
            4'd3:  ch = "P";
            4'd4:  ch = "T";
            4'd5:  ch = "E";
            4'd6:  ch = "R";
            4'd9:  ch = "N";
            4'd10: ch = "A";
            4'd11: ch = "M";
            4'd12: ch = "E";
            4'd13: ch = "=";
            default: ch = DIGIT_MARK;
        endcase
        return ch;
    endfunction

    // millisecond weight of each digit position of a time line
    function automatic logic [25:0] time_weight(input logic [4:0] idx);
        logic [25:0] w;
        unique case (idx)
            5'd10:   w = 26'd36000000;
            5'd11:   w = 26'd3600000;
            5'd13:   w = 26'd600000;
            5'd14:   w = 26'd60000;
            5'd16:   w = 26'd10000;
            5'd17:   w = 26'd1000;
            5'd19:   w = 26'd100;
            5'd20:   w = 26'd10;
            5'd21:   w = 26'd1;
            default: w = 26'd0;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/chapter_list_line_parser.sv
// ----------------------------------------------------------------------------
// chapter_list_line_parser
// Byte-wise parser for a simple chapter list with time and name lines.
// ----------------------------------------------------------------------------
// One text byte is taken per clock cycle while s_ready is high. Every byte is
// finished in that cycle by the line state update; its result, if any, sits
// in a single output register. s_ready is high whenever that register is
// empty or being taken, so with m_ready held high the block sustains one
// transfer per cycle. The line counters are NAME_COUNT_BITS+1 bits wide and
// saturate, so name lengths never wrap. No results follow an error until reset.
module chapter_list_line_parser #(
    parameter int NAME_COUNT_BITS = clp_pkg::NAME_COUNT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_char_byte,
    input  logic                s_end_of_text,
    output logic                m_valid,
    input  logic                m_ready,
    output clp_pkg::kind_t      m_kind,
    output logic [6:0]          m_chapter_number,
    output logic [26:0]         m_start_ms,
    output logic [7:0]          m_name_byte,
    output logic [15:0]         m_name_length,
    output clp_pkg::err_t       m_error_code,
    output logic                m_dropped_time
);
    import clp_pkg::*;

    localparam int CW = NAME_COUNT_BITS + 1;
    localparam logic [CW-1:0] COLUMN_CAP = CW'((64'd1 << NAME_COUNT_BITS) + 64'd31);
    localparam logic [CW-1:0] NAME_MAX   = CW'((64'd1 << NAME_COUNT_BITS) - 64'd1);

    logic            expect_name_reg, expect_name_next;
    logic            line_started_reg, line_started_next;
    logic [CW-1:0]   column_reg, column_next;
    logic [CW-1:0]   lnc_reg, lnc_next;
    logic            pattern_ok_reg, pattern_ok_next;
    logic [6:0]      chapter_reg, chapter_next;
    logic [6:0]      hour_reg, hour_next;
    logic [6:0]      minute_reg, minute_next;
    logic [6:0]      second_reg, second_next;
    logic [26:0]     acc_reg, acc_next;
    logic [26:0]     saved_start_reg, saved_start_next;
    logic            failed_reg, failed_next;

    logic            m_valid_reg;
    kind_t           kind_reg;
    logic [6:0]      chap_out_reg;
    logic [26:0]     start_out_reg;
    logic [7:0]      name_byte_reg;
    logic [15:0]     name_len_reg;
    err_t            err_reg;
    logic            dropped_reg;

    logic            res_valid;
    kind_t           res_kind;
    logic [6:0]      res_chap;
    logic [26:0]     res_start;
    logic [7:0]      res_name_byte;
    logic [15:0]     res_name_len;
    err_t            res_err;
    logic            res_dropped;

    logic            accept;
    logic            do_close;
    logic            ws;
    logic            digit;
    logic [3:0]      dval;
    logic [CW-1:0]   col;
    logic            pat;
    logic [7:0]      want;
    logic [6:0]      chap_b, hour_b, min_b, sec_b;
    logic [26:0]     acc_b;
    logic [CW-1:0]   name_len_raw, name_len_sat;
    logic [15:0]     name_len;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign ws    = is_ws(s_char_byte);
    assign digit = is_digit(s_char_byte);
    assign dval  = 4'(s_char_byte - CHAR_ZERO);
    assign col   = line_started_reg ? column_reg : '0;

    assign chap_b = line_started_reg ? chapter_reg : '0;
    assign hour_b = line_started_reg ? hour_reg    : '0;
    assign min_b  = line_started_reg ? minute_reg  : '0;
    assign sec_b  = line_started_reg ? second_reg  : '0;
    assign acc_b  = line_started_reg ? acc_reg     : '0;

    assign name_len_raw = lnc_reg - CW'(NAME_START - 1);
    assign name_len_sat = (name_len_raw > NAME_MAX) ? NAME_MAX : name_len_raw;
    assign name_len     = (64'(name_len_sat) > 64'd65535) ? 16'hFFFF : 16'(name_len_sat);

    always_comb begin
        expect_name_next  = expect_name_reg;
        line_started_next = line_started_reg;
        column_next       = column_reg;
        lnc_next          = lnc_reg;
        pattern_ok_next   = pattern_ok_reg;
        chapter_next      = chapter_reg;
        hour_next         = hour_reg;
        minute_next       = minute_reg;
        second_next       = second_reg;
        acc_next          = acc_reg;
        saved_start_next  = saved_start_reg;
        failed_next       = failed_reg;

        res_valid     = 1'b0;
        res_kind      = KIND_NAME_BYTE;
        res_chap      = '0;
        res_start     = '0;
        res_name_byte = '0;
        res_name_len  = '0;
        res_err       = ERR_NONE;
        res_dropped   = 1'b0;

        do_close = 1'b0;
        pat      = 1'b1;
        want     = DIGIT_MARK;

        if (accept && !failed_reg) begin
            if (s_end_of_text) begin
                if (line_started_reg) begin
                    do_close = 1'b1;
                end else begin
                    res_valid        = 1'b1;
                    res_kind         = KIND_END;
                    res_dropped      = expect_name_reg;
                    res_chap         = expect_name_reg ? chapter_reg : '0;
                    res_start        = expect_name_reg ? saved_start_reg : '0;
                    expect_name_next = 1'b0;
                end
            end else if (s_char_byte == CHAR_NEWLINE) begin
                do_close = line_started_reg;
            end else if (line_started_reg || !ws) begin
                line_started_next = 1'b1;
                pat               = line_started_reg ? pattern_ok_reg : 1'b1;
                chapter_next      = chap_b;
                hour_next         = hour_b;
                minute_next       = min_b;
                second_next       = sec_b;
                acc_next          = acc_b;

                if (!expect_name_reg) begin
                    if (col < CW'(TIME_LINE_LEN)) begin
                        want = time_shape(col[4:0]);
                        if (want == DIGIT_MARK) begin
                            if (!digit) begin
                                pat = 1'b0;
                            end else begin
                                acc_next = acc_b + 27'(time_weight(col[4:0])) * 27'(dval);
                                unique case (col[4:0])
                                    5'd7, 5'd8:   chapter_next = 7'(chap_b * 7'd10 + 7'(dval));
                                    5'd10, 5'd11: hour_next    = 7'(hour_b * 7'd10 + 7'(dval));
                                    5'd13, 5'd14: minute_next  = 7'(min_b * 7'd10 + 7'(dval));
                                    5'd16, 5'd17: second_next  = 7'(sec_b * 7'd10 + 7'(dval));
                                    default: ;
                                endcase
                            end
                        end else if (s_char_byte != want) begin
                            pat = 1'b0;
                        end
                    end else if (!ws) begin
                        pat = 1'b0;
                    end
                end else begin
                    if (col < CW'(NAME_START)) begin
                        want = name_shape(col[3:0]);
                        if (want == DIGIT_MARK) begin
                            if (!digit) begin
                                pat = 1'b0;
                            end else begin
                                chapter_next = 7'(chap_b * 7'd10 + 7'(dval));
                            end
                        end else if (s_char_byte != want) begin
                            pat = 1'b0;
                        end
                    end else begin
                        if (col == CW'(NAME_START) && ws) begin
                            pat = 1'b0;
                        end
                        if (pat) begin
                            res_valid     = 1'b1;
                            res_kind      = KIND_NAME_BYTE;
                            res_chap      = chap_b;
                            res_name_byte = s_char_byte;
                        end
                    end
                end

                pattern_ok_next = pat;
                if (!ws) begin
                    lnc_next = col;
                end else if (!line_started_reg) begin
                    lnc_next = '0;
                end
                column_next = (col < COLUMN_CAP) ? col + CW'(1) : col;
            end
        end

        if (do_close) begin
            line_started_next = 1'b0;
            res_valid         = 1'b1;
            if (!expect_name_reg) begin
                priority if (!pattern_ok_reg || lnc_reg != CW'(TIME_LINE_LAST)) begin
                    res_err = ERR_BAD_TIME;
                end else if (hour_reg > 7'(HOUR_MAX)) begin
                    res_err = ERR_HOUR;
                end else if (minute_reg > 7'(MINUTE_MAX)) begin
                    res_err = ERR_MINUTE;
                end else if (second_reg > 7'(SECOND_MAX)) begin
                    res_err = ERR_SECOND;
                end else begin
                    expect_name_next = 1'b1;
                    saved_start_next = acc_reg;
                    res_kind         = KIND_TIME;
                    res_chap         = chapter_reg;
                    res_start        = acc_reg;
                end
            end else if (!pattern_ok_reg || lnc_reg < CW'(NAME_START)) begin
                res_err = ERR_BAD_NAME;
            end else begin
                expect_name_next = 1'b0;
                res_kind         = KIND_CHAPTER;
                res_chap         = chapter_reg;
                res_start        = saved_start_reg;
                res_name_len     = name_len;
            end
            if (res_err != ERR_NONE) begin
                failed_next = 1'b1;
                res_kind    = KIND_ERROR;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_name_reg  <= 1'b0;
            line_started_reg <= 1'b0;
            column_reg       <= '0;
            lnc_reg          <= '0;
            pattern_ok_reg   <= 1'b1;
            chapter_reg      <= '0;
            hour_reg         <= '0;
            minute_reg       <= '0;
            second_reg       <= '0;
            acc_reg          <= '0;
            saved_start_reg  <= '0;
            failed_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            expect_name_reg  <= expect_name_next;
            line_started_reg <= line_started_next;
            column_reg       <= column_next;
            lnc_reg          <= lnc_next;
            pattern_ok_reg   <= pattern_ok_next;
            chapter_reg      <= chapter_next;
            hour_reg         <= hour_next;
            minute_reg       <= minute_next;
            second_reg       <= second_next;
            acc_reg          <= acc_next;
            saved_start_reg  <= saved_start_next;
            failed_reg       <= failed_next;
            if (s_ready) begin
                m_valid_reg <= res_valid;
            end
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            kind_reg      <= res_kind;
            chap_out_reg  <= res_chap;
            start_out_reg <= res_start;
            name_byte_reg <= res_name_byte;
            name_len_reg  <= res_name_len;
            err_reg       <= res_err;
            dropped_reg   <= res_dropped;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = kind_reg;
    assign m_chapter_number = chap_out_reg;
    assign m_start_ms       = start_out_reg;
    assign m_name_byte      = name_byte_reg;
    assign m_name_length    = name_len_reg;
    assign m_error_code     = err_reg;
    assign m_dropped_time   = dropped_reg;

endmodule

>>> rtl/clp_checker.sv
// ----------------------------------------------------------------------------
// clp_checker
// Port-level checks for the chapter list parser, bound to the top level.
// ----------------------------------------------------------------------------
module clp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input clp_pkg::kind_t      m_kind,
    input logic [6:0]          m_chapter_number,
    input logic [26:0]         m_start_ms,
    input logic [7:0]          m_name_byte,
    input clp_pkg::err_t       m_error_code,
    input logic                m_dropped_time
);
    import clp_pkg::*;

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_name_byte))
        else $error("result changed while stalled");

    // error is sticky: nothing follows an error transfer
    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_kind == KIND_ERROR |=> !m_valid)
        else $error("result after error");

    a_error_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_kind == KIND_ERROR) == (m_error_code != ERR_NONE)))
        else $error("error code does not match kind");

    a_name_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_NAME_BYTE |-> m_name_byte == 8'd0)
        else $error("name byte set outside name byte result");

    a_end_plain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_END && !m_dropped_time
            |-> m_start_ms == 27'd0 && m_chapter_number == 7'd0)
        else $error("end of text carries chapter without dropped time");

endmodule

bind chapter_list_line_parser clp_checker u_clp_checker (.*);
